// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CPLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CPLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cpls_pkg.sv -----
// Types, constants and pin pattern tables for the charlieplexed LED scanner
`timescale 1ns / 1ps

package cpls_pkg;

    localparam int LEVELS     = 32;
    localparam int NUM_LEDS   = 6;
    localparam int LED_W      = 3;
    localparam int BRIGHT_W   = 8;
    localparam int PIN_W      = 3;
    localparam int SLOT_W     = $clog2((LEVELS > NUM_LEDS) ? LEVELS : NUM_LEDS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int CMP_W      = BRIGHT_W + 1;
    localparam int SLOT_RESET = 5;

    typedef logic [LED_W-1:0]    led_idx_t;
    typedef logic [BRIGHT_W-1:0] bright_t;
    typedef logic [PIN_W-1:0]    pins_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } cmd_t;

    function automatic led_idx_t next_led(input led_idx_t idx);
        led_idx_t res;
        if (idx >= LED_W'(NUM_LEDS - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + LED_W'(1);
        end
        return res;
    endfunction

    // Driven levels per LED: the anode pin high, the cathode pin low
    function automatic pins_t pat_level(input led_idx_t idx);
        pins_t res;
        unique case (idx)
            3'd0:    res = 3'b100;
            3'd1:    res = 3'b001;
            3'd2:    res = 3'b010;
            3'd3:    res = 3'b100;
            3'd4:    res = 3'b001;
            3'd5:    res = 3'b010;
            default: res = '0;
        endcase
        return res;
    endfunction

    // Enabled pins per LED: the two pins across the LED
    function automatic pins_t pat_enable(input led_idx_t idx);
        pins_t res;
        unique case (idx)
            3'd0:    res = 3'b101;
            3'd1:    res = 3'b101;
            3'd2:    res = 3'b011;
            3'd3:    res = 3'b110;
            3'd4:    res = 3'b011;
            3'd5:    res = 3'b110;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/cpls_ram.sv -----
// Generic RAM: one write port, two registered read ports
`timescale 1ns / 1ps

module cpls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- hdl/charlieplex_pwm_led_scanner.sv -----
// Top level of the charlieplexed six-LED PWM scanner
// Takes one beat per clock while req_stall is low and returns one result beat per
// request: the request first lands in an item register (the brightness RAM reads
// during that edge), then the state update and readback go to the result registers.
// Throughput is set by the single state update path (slot counter increment and
// compare, pattern select), one request per cycle when not stalled. Brightness lives
// in a six-entry RAM with per-entry valid bits, so it reads as zero after reset with
// no clearing pass. A tick beat advances the PWM slot; a set beat stores one brightness.
`timescale 1ns / 1ps

module charlieplex_pwm_led_scanner (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     cmd,
    input  logic [2:0]               led_index,
    input  logic [7:0]               brightness,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [2:0]               pin_level,
    output logic [2:0]               pin_enable,
    output logic [2:0]               active_led,
    output logic [7:0]               read_brightness
);

    // item register
    logic                       s1_valid_reg;
    cpls_pkg::cmd_t             s1_cmd_reg;
    cpls_pkg::led_idx_t         s1_idx_reg;
    cpls_pkg::bright_t          s1_bright_reg;

    // RAM bypass: own write or never-written entry
    logic                       use_a_reg, use_a_next;
    cpls_pkg::bright_t          byp_a_reg, byp_a_next;
    logic                       use_b_reg, use_b_next;
    cpls_pkg::bright_t          byp_b_reg, byp_b_next;

    // scanner state
    logic [cpls_pkg::NUM_LEDS-1:0] led_vld_reg, led_vld_next;
    cpls_pkg::slot_t            slot_reg, slot_next;
    cpls_pkg::led_idx_t         scan_reg, scan_next;
    cpls_pkg::bright_t          cur_level_reg, cur_level_next;
    cpls_pkg::pins_t            level_bits_reg, level_bits_next;
    cpls_pkg::pins_t            enable_bits_reg, enable_bits_next;

    // result register
    logic                       rsp_valid_reg, rsp_valid_next;
    cpls_pkg::bright_t          rd_bright_reg, rd_bright_next;

    logic                       adv;
    logic                       req_acc;
    logic                       req_idx_ok;
    logic                       s1_idx_ok;
    logic                       wr_en;
    logic                       hit_a;
    logic                       hit_b;
    cpls_pkg::led_idx_t         rd_addr_a;
    cpls_pkg::led_idx_t         rd_addr_b;
    cpls_pkg::bright_t          ram_a;
    cpls_pkg::bright_t          ram_b;
    cpls_pkg::bright_t          level_a;
    cpls_pkg::bright_t          level_b;
    logic [cpls_pkg::CNT_W-1:0] cnt_inc;
    logic                       wrap;
    cpls_pkg::slot_t            tick_slot;
    cpls_pkg::led_idx_t         tick_scan;
    cpls_pkg::bright_t          tick_level;

    // handshake: the item register moves on when the result register is free
    assign adv       = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !adv;
    assign req_acc   = req_valid && !req_stall;

    assign req_idx_ok = led_index < cpls_pkg::LED_W'(cpls_pkg::NUM_LEDS);
    assign s1_idx_ok  = s1_idx_reg < cpls_pkg::LED_W'(cpls_pkg::NUM_LEDS);
    assign wr_en      = adv && (s1_cmd_reg == cpls_pkg::CMD_SET) && s1_idx_ok;

    // read the requested LED and prefetch the LED after the one scanning next
    assign rd_addr_a = req_idx_ok ? led_index : '0;
    assign rd_addr_b = cpls_pkg::next_led(scan_next);
    assign hit_a     = wr_en && (s1_idx_reg == rd_addr_a);
    assign hit_b     = wr_en && (s1_idx_reg == rd_addr_b);

    always_comb
    begin
        use_a_next = !req_idx_ok || hit_a || !led_vld_reg[rd_addr_a];
        byp_a_next = (req_idx_ok && hit_a) ? s1_bright_reg : '0;
        use_b_next = hit_b || !led_vld_reg[rd_addr_b];
        byp_b_next = hit_b ? s1_bright_reg : '0;
    end

    cpls_ram #(
        .WIDTH (cpls_pkg::BRIGHT_W),
        .DEPTH (cpls_pkg::NUM_LEDS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (s1_idx_reg),
        .wr_data   (s1_bright_reg),
        .rd_en     (req_acc),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (ram_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (ram_b)
    );

    assign level_a = use_a_reg ? byp_a_reg : ram_a;
    assign level_b = use_b_reg ? byp_b_reg : ram_b;

    // tick path
    always_comb
    begin
        cnt_inc    = cpls_pkg::CNT_W'(slot_reg) + cpls_pkg::CNT_W'(1);
        wrap       = cnt_inc >= cpls_pkg::CNT_W'(cpls_pkg::LEVELS);
        tick_slot  = wrap ? '0 : cnt_inc[cpls_pkg::SLOT_W-1:0];
        tick_scan  = wrap ? cpls_pkg::next_led(scan_reg) : scan_reg;
        tick_level = wrap ? level_b : cur_level_reg;
    end

    always_comb
    begin
        led_vld_next     = led_vld_reg;
        slot_next        = slot_reg;
        scan_next        = scan_reg;
        cur_level_next   = cur_level_reg;
        level_bits_next  = level_bits_reg;
        enable_bits_next = enable_bits_reg;
        rd_bright_next   = rd_bright_reg;
        if (adv)
        begin
            if (s1_cmd_reg == cpls_pkg::CMD_SET)
            begin
                if (s1_idx_ok)
                begin
                    led_vld_next[s1_idx_reg] = 1'b1;
                    if (s1_idx_reg == scan_reg)
                    begin
                        cur_level_next = s1_bright_reg;
                    end
                end
                rd_bright_next = s1_idx_ok ? s1_bright_reg : '0;
            end
            else
            begin
                slot_next      = tick_slot;
                scan_next      = tick_scan;
                cur_level_next = tick_level;
                if (wrap && (tick_level != '0))
                begin
                    level_bits_next  = cpls_pkg::pat_level(tick_scan);
                    enable_bits_next = cpls_pkg::pat_enable(tick_scan);
                end
                // float all pins once the on-time is used up
                if (cpls_pkg::CMP_W'(tick_slot) == cpls_pkg::CMP_W'(tick_level))
                begin
                    level_bits_next  = '0;
                    enable_bits_next = '0;
                end
                rd_bright_next = s1_idx_ok ? level_a : '0;
            end
        end
    end

    always_comb
    begin
        if (adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            led_vld_reg     <= '0;
            slot_reg        <= cpls_pkg::SLOT_W'(cpls_pkg::SLOT_RESET);
            scan_reg        <= '0;
            cur_level_reg   <= '0;
            level_bits_reg  <= '0;
            enable_bits_reg <= '0;
        end
        else
        begin
            if (req_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            rsp_valid_reg   <= rsp_valid_next;
            led_vld_reg     <= led_vld_next;
            slot_reg        <= slot_next;
            scan_reg        <= scan_next;
            cur_level_reg   <= cur_level_next;
            level_bits_reg  <= level_bits_next;
            enable_bits_reg <= enable_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_cmd_reg    <= cpls_pkg::cmd_t'(cmd);
            s1_idx_reg    <= led_index;
            s1_bright_reg <= brightness;
            use_a_reg     <= use_a_next;
            byp_a_reg     <= byp_a_next;
            use_b_reg     <= use_b_next;
            byp_b_reg     <= byp_b_next;
        end
        rd_bright_reg <= rd_bright_next;
    end

    // pins and scan index hold while the result waits, since state moves only on advance
    assign rsp_valid       = rsp_valid_reg;
    assign pin_level       = level_bits_reg;
    assign pin_enable      = enable_bits_reg;
    assign active_led      = scan_reg;
    assign read_brightness = rd_bright_reg;

endmodule

// ----- hdl/cpls_checker.sv -----
// Port-level checks for the charlieplexed LED scanner, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpls_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [2:0] pin_level,
    input logic [2:0] pin_enable,
    input logic [2:0] active_led,
    input logic [7:0] read_brightness
);

    `CPLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(pin_level) && $stable(pin_enable) && $stable(active_led) && $stable(read_brightness), "result beat changed while stalled")

    `CPLS_ASSERT_NOW(a_scan_range, rsp_valid, active_led <= 3'd5, "active LED out of range")

    `CPLS_ASSERT_NOW(a_two_pins, rsp_valid, (pin_enable == 3'b000) || ($countones(pin_enable) == 2), "pins driven other than in pairs")

    `CPLS_ASSERT_NOW(a_level_in_enable, rsp_valid, (pin_level & ~pin_enable) == 3'b000, "level set on a floating pin")

endmodule

bind charlieplex_pwm_led_scanner cpls_checker u_cpls_checker (.*);

// ----- dv/cpls_scan_checker.sv -----
// Checker for the charlieplexed LED scanner: predicts each result beat and compares it
`timescale 1ns / 1ps

module cpls_scan_checker
    import cpls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  logic       cmd,
    input  logic [2:0] led_index,
    input  logic [7:0] brightness,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  logic [2:0] pin_level,
    input  logic [2:0] pin_enable,
    input  logic [2:0] active_led,
    input  logic [7:0] read_brightness,
    output int         errors,
    output int         pending
);

    typedef struct packed {
        logic [2:0] level;
        logic [2:0] enable;
        logic [2:0] led;
        logic [7:0] readback;
    } scan_rsp_t;

    // Anode high / cathode low, and the two pins across each LED
    localparam logic [2:0] LED_PIN_LEVEL  [NUM_LEDS] = '{3'b100, 3'b001, 3'b010,
                                                         3'b100, 3'b001, 3'b010};
    localparam logic [2:0] LED_PIN_ENABLE [NUM_LEDS] = '{3'b101, 3'b101, 3'b011,
                                                         3'b110, 3'b011, 3'b110};

    logic [7:0] led_brt [NUM_LEDS];
    int         slot_cnt;
    logic [2:0] scan_led;
    logic [2:0] drv_level;
    logic [2:0] drv_enable;

    scan_rsp_t  scan_rsp_q [$];
    scan_rsp_t  want;
    int         new_errs;

    function automatic scan_rsp_t predict_scan_rsp(input logic c, input logic [2:0] idx,
                                                   input logic [7:0] val);
        scan_rsp_t r;
        if (c == CMD_SET)
        begin
            if (idx < NUM_LEDS)
            begin
                led_brt[idx] = val;
            end
        end
        else
        begin
            slot_cnt = slot_cnt + 1;
            if (slot_cnt >= LEVELS)
            begin
                slot_cnt = 0;
                scan_led = (scan_led >= NUM_LEDS - 1) ? 3'd0 : scan_led + 3'd1;
                if (led_brt[scan_led] != 8'd0)
                begin
                    drv_level  = LED_PIN_LEVEL[scan_led];
                    drv_enable = LED_PIN_ENABLE[scan_led];
                end
            end
            // Float all pins once the on-time of the active LED is used up
            if (slot_cnt == int'(led_brt[scan_led]))
            begin
                drv_level  = 3'd0;
                drv_enable = 3'd0;
            end
        end
        r.level    = drv_level;
        r.enable   = drv_enable;
        r.led      = scan_led;
        r.readback = (idx < NUM_LEDS) ? led_brt[idx] : 8'd0;
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [7:0] exp_val,
                                     input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                led_brt[i] = 8'd0;
            end
            slot_cnt   = SLOT_RESET;
            scan_led   = 3'd0;
            drv_level  = 3'd0;
            drv_enable = 3'd0;
            scan_rsp_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            new_errs = 0;
            if (req_valid && !req_stall)
            begin
                scan_rsp_q.push_back(predict_scan_rsp(cmd, led_index, brightness));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (scan_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, actual %0h %0h %0h %0h",
                             $time, pin_level, pin_enable, active_led, read_brightness);
                    new_errs++;
                end
                else
                begin
                    want = scan_rsp_q.pop_front();
                    new_errs += field_bad("pin_level", 8'(want.level), 8'(pin_level));
                    new_errs += field_bad("pin_enable", 8'(want.enable), 8'(pin_enable));
                    new_errs += field_bad("active_led", 8'(want.led), 8'(active_led));
                    new_errs += field_bad("read_brightness", want.readback, read_brightness);
                end
            end
            errors  <= errors + new_errs;
            pending <= scan_rsp_q.size();
        end
    end

endmodule

// ----- dv/charlieplex_pwm_led_scanner_tb.sv -----
// Testbench top for the charlieplexed LED scanner: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module charlieplex_pwm_led_scanner_tb;

    import cpls_pkg::*;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       req_valid       = 1'b0;
    logic       cmd             = 1'b0;
    logic [2:0] led_index       = 3'd0;
    logic [7:0] brightness      = 8'd0;
    logic       rsp_stall       = 1'b0;
    logic       req_stall;
    logic       rsp_valid;
    logic [2:0] pin_level;
    logic [2:0] pin_enable;
    logic [2:0] active_led;
    logic [7:0] read_brightness;

    int         errors;
    int         pending;
    logic       hold_off_req    = 1'b0;
    int         tx_quiet        = 0;
    int         rx_quiet        = 0;
    int         beats_done      = 0;

    always #5 clk = ~clk;

    charlieplex_pwm_led_scanner i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .cmd             (cmd),
        .led_index       (led_index),
        .brightness      (brightness),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .pin_level       (pin_level),
        .pin_enable      (pin_enable),
        .active_led      (active_led),
        .read_brightness (read_brightness)
    );

    cpls_scan_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .cmd             (cmd),
        .led_index       (led_index),
        .brightness      (brightness),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .pin_level       (pin_level),
        .pin_enable      (pin_enable),
        .active_led      (active_led),
        .read_brightness (read_brightness),
        .errors          (errors),
        .pending         (pending)
    );

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int idle_len(inout int quiet_left);
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'(LEVELS - 1);
            3:       return 8'(LEVELS);
            4:       return 8'(LEVELS + 1);
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input cmd_t c, input logic [2:0] idx, input logic [7:0] val);
        int gap;
        req_valid  <= 1'b1;
        cmd        <= c;
        led_index  <= idx;
        brightness <= val;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        if (!(c == CMD_SET && idx >= NUM_LEDS))
        begin
            beats_done++;
        end
        gap = idle_len(tx_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [2:0] idx;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(CMD_TICK, 3'd0, 8'h00);
        send_beat(CMD_SET, 3'd0, 8'hFF);
        send_beat(CMD_SET, 3'd1, 8'hAA);
        send_beat(CMD_SET, 3'd2, 8'h55);
        send_beat(CMD_SET, 3'd3, 8'(LEVELS));
        send_beat(CMD_SET, 3'd4, 8'(LEVELS - 1));
        send_beat(CMD_SET, 3'd5, 8'd1);
        // Writes to the nonexistent LEDs must not land anywhere
        send_beat(CMD_SET, 3'd6, 8'hFF);
        send_beat(CMD_SET, 3'd7, 8'h80);
        send_beat(CMD_TICK, 3'd6, 8'hFF);
        send_beat(CMD_TICK, 3'd7, 8'h00);
        send_beat(CMD_SET, 3'd1, 8'h00);
        send_beat(CMD_TICK, 3'd1, 8'h5A);
        send_beat(CMD_SET, 3'd2, 8'h00);
        send_beat(CMD_TICK, 3'd2, 8'hA5);

        while (beats_done < 550)
        begin
            if (beats_done == 150 && !hold_off_req)
            begin
                hold_off_req <= 1'b1;
                tx_quiet = 80;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                send_beat(CMD_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                idx = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, NUM_LEDS - 1));
                send_beat(CMD_SET, idx, pick_level());
            end
        end
        req_valid <= 1'b0;

        // Let the checker count the last accepted beat before draining
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back up the pipeline
    initial
    begin
        int  stall_len;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                stall_len = 150;
            end
            else
            begin
                stall_len = idle_len(rx_quiet);
            end
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
